/* rtl/assert_macros.svh */
// assertion macros shared by the rtl of the proximity coverage histogram
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, expr)
`endif

`endif

/* rtl/tpch_pkg.sv */
// shared constants, field widths and sequencer states of the histogram
// no dependencies
`timescale 1ns / 1ps

package tpch_pkg;

   localparam int NUM_BINS_DEF    = 800;
   localparam int COUNT_WIDTH_DEF = 32;
   localparam int POS_PER_BIN     = 5;
   localparam int PRE_WINDOW      = 3000;

   localparam int DIST_W  = 32;
   localparam int SIZE_W  = 24;
   localparam int INDEX_W = 10;
   localparam int OUT_W   = 32;

   // shared subtractor width, dividend width and reciprocal of five
   localparam int SUB_W     = 34;
   localparam int DIV_W     = 24;
   localparam int QUO_W     = 22;
   localparam int DIV_SHIFT = 26;
   localparam logic [DIV_W-1:0] DIV_RECIP = 24'hCC_CCCD;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_NEG_CHK,
      ST_DIV,
      ST_REM,
      ST_ADJ,
      ST_RUN,
      ST_READ_WAIT
   } state_type;

endpackage

/* rtl/tpch_ram.sv */
// generic simple dual port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module tpch_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 800,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/tpch_sub.sv */
// shared signed subtractor used by the check, remainder, adjust and run steps of the sequencer
// depends on tpch_pkg
`timescale 1ns / 1ps

module tpch_sub
   import tpch_pkg::*;
(
   input  logic signed [SUB_W-1:0] op_a,
   input  logic signed [SUB_W-1:0] op_b,
   output logic signed [SUB_W-1:0] diff,
   output logic                    negative
);

   assign diff     = op_a - op_b;
   assign negative = diff[SUB_W-1];

endmodule

/* rtl/tss_proximity_coverage_histogram.sv */
// top level: sequencer, bin counter ram and shared subtractor
// depends on tpch_pkg, tpch_ram, tpch_sub and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keeps NUM_BINS saturating counters of 5 positions each over a window that opens 3000
// positions before a start site. After reset a clearing pass zeroes every bin of the
// counter ram; requests are stalled meanwhile. One request is worked on at a time. An
// add request whose peak starts inside the window goes through a check, a divide step
// (multiply by the reciprocal of five) to find the first bin, then the bin loop, which
// ends by finishing the last read-modify-write. A peak that starts before the window
// adds a lead-in check, a remainder step and an adjust step before the bin loop. A peak
// that lies past the window is dropped after the check, one that ends before it after
// the lead-in check. A read request goes through the registered ram read and waits
// while an earlier result is still stalled. The bin loop is paced by one
// read-modify-write of the counter ram per cycle. A finished read result is held in an
// output register while the next request is accepted.
module tss_proximity_coverage_histogram
   import tpch_pkg::*;
#(
   parameter int NUM_BINS    = NUM_BINS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_mode,
   input  logic signed [DIST_W-1:0]  req_tss_distance,
   input  logic        [SIZE_W-1:0]  req_peak_size,
   input  logic        [INDEX_W-1:0] req_bin_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic        [INDEX_W-1:0] rsp_read_bin,
   output logic        [OUT_W-1:0]   rsp_bin_count
);

   localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CBITS = $clog2(NUM_BINS + 1);
   localparam int WINDOW_TOP = NUM_BINS * POS_PER_BIN - 1;

   state_type state_ff, state_in;

   logic [CBITS-1:0]       clr_ff, clr_in;
   logic                   pend_ff, pend_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   logic signed [SUB_W-1:0] start_ff, start_in;
   logic signed [SUB_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic                   neg_ff, neg_in;
   logic [DIV_W-1:0]       dvd_ff, dvd_in;
   logic [QUO_W-1:0]       quo_ff, quo_in;
   logic [2:0]             r_ff, r_in;
   logic [CBITS-1:0]       bin_ff, bin_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [INDEX_W-1:0]     rsp_bin_ff, rsp_bin_in;
   logic [OUT_W-1:0]       rsp_count_ff, rsp_count_in;

   logic signed [SUB_W-1:0] sub_a, sub_b, sub_diff;
   logic                   sub_neg;

   logic                   ram_wr_en, ram_rd_en;
   logic [AW-1:0]          ram_wr_addr, ram_rd_addr;
   logic [COUNT_WIDTH-1:0] ram_wr_data, ram_rd_data, count_inc;
   logic [63:0]            count_ext;

   logic                   accept, idx_in_range, run_go;
   logic [2*DIV_W-1:0]     div_prod;
   logic [QUO_W-1:0]       div_quo;
   logic [2:0]             cur0;

   tpch_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (NUM_BINS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tpch_sub u_sub (
      .op_a     (sub_a),
      .op_b     (sub_b),
      .diff     (sub_diff),
      .negative (sub_neg)
   );

   assign req_stall     = (state_ff != ST_IDLE);
   assign accept        = req_valid && !req_stall;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_bin  = rsp_bin_ff;
   assign rsp_bin_count = rsp_count_ff;

   assign idx_in_range = (32'(idx_ff) < 32'(NUM_BINS));
   assign run_go       = !rem_ff[SUB_W-1] && (bin_ff < CBITS'(NUM_BINS));
   assign div_prod     = (2*DIV_W)'(dvd_ff) * (2*DIV_W)'(DIV_RECIP);
   assign div_quo      = div_prod[DIV_SHIFT +: QUO_W];
   assign cur0         = (r_ff == 3'd0) ? 3'd0 : 3'(POS_PER_BIN) - r_ff;
   assign count_ext    = 64'(ram_rd_data);
   assign count_inc    = (ram_rd_data == {COUNT_WIDTH{1'b1}}) ? ram_rd_data
                                                             : ram_rd_data + COUNT_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      rem_ff       <= rem_in;
      size_ff      <= size_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      quo_ff       <= quo_in;
      r_ff         <= r_in;
      bin_ff       <= bin_in;
      pend_addr_ff <= pend_addr_in;
      idx_ff       <= idx_in;
      rsp_bin_ff   <= rsp_bin_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      pend_in      = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      start_in     = start_ff;
      rem_in       = rem_ff;
      size_in      = size_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      quo_in       = quo_ff;
      r_in         = r_ff;
      bin_in       = bin_ff;
      pend_addr_in = pend_addr_ff;
      idx_in       = idx_ff;
      rsp_bin_in   = rsp_bin_ff;
      rsp_count_in = rsp_count_ff;

      sub_a       = '0;
      sub_b       = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = pend_addr_ff;
      ram_wr_data = count_inc;
      ram_rd_en   = 1'b0;
      ram_rd_addr = bin_ff[AW-1:0];

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff[AW-1:0];
            ram_wr_data = '0;
            clr_in      = clr_ff + CBITS'(1);
            if (clr_ff == CBITS'(NUM_BINS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  idx_in = req_bin_index;
                  ram_rd_en   = (32'(req_bin_index) < 32'(NUM_BINS));
                  ram_rd_addr = AW'(req_bin_index);
                  state_in = ST_READ_WAIT;
               end else begin
                  start_in = SUB_W'(req_tss_distance) + SUB_W'(PRE_WINDOW);
                  size_in  = req_peak_size;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (start_ff[SUB_W-1]) begin
               // negate start to get the lead-in length
               sub_a    = '0;
               sub_b    = start_ff;
               rem_in   = sub_diff;
               state_in = ST_NEG_CHK;
            end else begin
               sub_a = SUB_W'(WINDOW_TOP);
               sub_b = start_ff;
               if (sub_neg) begin
                  state_in = ST_IDLE;
               end else begin
                  dvd_in   = start_ff[DIV_W-1:0];
                  rem_in   = SUB_W'(size_ff);
                  neg_in   = 1'b0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_NEG_CHK: begin
            sub_a = SUB_W'(size_ff);
            sub_b = rem_ff;
            if (sub_neg) begin
               state_in = ST_IDLE;
            end else begin
               dvd_in   = rem_ff[DIV_W-1:0];
               rem_in   = sub_diff;
               neg_in   = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // divide by five through the reciprocal, exact below 2**24
            if (neg_ff) begin
               quo_in   = div_quo;
               bin_in   = '0;
               state_in = ST_REM;
            end else begin
               bin_in   = CBITS'(div_quo);
               state_in = ST_RUN;
            end
         end
         ST_REM: begin
            // lead-in length modulo five
            sub_a    = SUB_W'(dvd_ff);
            sub_b    = SUB_W'(quo_ff) + SUB_W'({quo_ff, 2'b00});
            r_in     = sub_diff[2:0];
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            // step up to the first visited position at or after zero
            sub_a    = rem_ff;
            sub_b    = SUB_W'(cur0);
            rem_in   = sub_diff;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            sub_a = rem_ff;
            sub_b = SUB_W'(POS_PER_BIN);
            if (pend_ff) begin
               ram_wr_en = 1'b1;
            end
            if (run_go) begin
               ram_rd_en    = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = bin_ff[AW-1:0];
               bin_in       = bin_ff + CBITS'(1);
               rem_in       = sub_diff;
            end else if (!pend_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_READ_WAIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_bin_in   = idx_ff;
               rsp_count_in = idx_in_range ? count_ext[OUT_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_IMPL(a_rmw_addr, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr)
   `ASSERT_IMPL(a_adj_rem, clock, reset, state_ff == ST_ADJ, r_ff < 3'(POS_PER_BIN))
   `ASSERT_IMPL(a_rsp_load, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_READ_WAIT)
   `ASSERT_IMPL(a_bin_bound, clock, reset, state_ff == ST_RUN, bin_ff <= CBITS'(NUM_BINS))

endmodule

/* test/tb_tss_proximity_coverage_histogram.sv */
// testbench for tss_proximity_coverage_histogram: directed and random peak adds and bin reads,
// checked against an in-bench bin tally kept by a small scoreboard class
// depends on tpch_pkg and the histogram rtl
`timescale 1ns / 1ps

module tb_tss_proximity_coverage_histogram;
   import tpch_pkg::*;

   localparam logic MODE_ADD  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   localparam int     WINDOW_TOP      = NUM_BINS_DEF * POS_PER_BIN - 1;
   localparam int     RANDOM_REQUESTS = 1800;
   localparam int     QUIET_TAIL      = 250;
   localparam int     HOLD_START      = 400;
   localparam int     HOLD_CYCLES     = 2500;
   localparam int     DRAIN_CYCLES    = 900;
   localparam longint CYCLE_LIMIT     = 7_000_000;

   class coverage_scoreboard;
      bit   [COUNT_WIDTH_DEF-1:0] bin_tally [NUM_BINS_DEF];
      logic [INDEX_W-1:0]         read_bins [$];
      logic [OUT_W-1:0]           read_counts [$];
      int unsigned                errors;

      function void add_peak(longint distance, longint size);
         longint pos;
         longint last;
         pos  = distance + PRE_WINDOW;
         last = pos + size;
         // step up to the first visited position inside the window
         if (pos < 0)
            pos += ((-pos + POS_PER_BIN - 1) / POS_PER_BIN) * POS_PER_BIN;
         while (pos <= last && pos <= WINDOW_TOP) begin
            if (bin_tally[pos / POS_PER_BIN] != '1)
               bin_tally[pos / POS_PER_BIN]++;
            pos += POS_PER_BIN;
         end
      endfunction

      function void note_request(logic mode, logic signed [DIST_W-1:0] distance,
                                 logic [SIZE_W-1:0] size, logic [INDEX_W-1:0] bin);
         logic [OUT_W-1:0] count;
         if (mode == MODE_ADD) begin
            add_peak(longint'(distance), longint'(size));
         end else begin
            count = '0;
            if (bin < NUM_BINS_DEF)
               count = bin_tally[bin][OUT_W-1:0];
            read_bins.push_back(bin);
            read_counts.push_back(count);
         end
      endfunction

      function void check_result(logic [INDEX_W-1:0] bin, logic [OUT_W-1:0] count);
         logic [INDEX_W-1:0] want_bin;
         logic [OUT_W-1:0]   want_count;
         if (read_bins.size() == 0) begin
            $display("%0t: unexpected read result, expected none, got bin %0d count %0d",
                     $time, bin, count);
            errors++;
            return;
         end
         want_bin   = read_bins.pop_front();
         want_count = read_counts.pop_front();
         if (bin !== want_bin) begin
            $display("%0t: read_bin mismatch, expected %0d, got %0d", $time, want_bin, bin);
            errors++;
         end
         if (count !== want_count) begin
            $display("%0t: bin_count mismatch for bin %0d, expected %0d, got %0d",
                     $time, want_bin, want_count, count);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_mode = MODE_ADD;
   logic signed [DIST_W-1:0]  req_tss_distance = '0;
   logic        [SIZE_W-1:0]  req_peak_size = '0;
   logic        [INDEX_W-1:0] req_bin_index = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic        [INDEX_W-1:0] rsp_read_bin;
   logic        [OUT_W-1:0]   rsp_bin_count;

   coverage_scoreboard sb = new();

   int     requests_sent = 0;
   int     send_gap_pct  = 0;
   int     rsp_gap_pct   = 0;
   int     stall_left    = 0;
   logic   rsp_hold      = 1'b0;
   longint cycle_count   = 0;

   tss_proximity_coverage_histogram dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_tss_distance (req_tss_distance),
      .req_peak_size    (req_peak_size),
      .req_bin_index    (req_bin_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_bin     (rsp_read_bin),
      .rsp_bin_count    (rsp_bin_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic send_request(input logic mode, input logic signed [DIST_W-1:0] distance,
                               input logic [SIZE_W-1:0] size, input logic [INDEX_W-1:0] bin);
      req_valid        <= 1'b1;
      req_mode         <= mode;
      req_tss_distance <= distance;
      req_peak_size    <= size;
      req_bin_index    <= bin;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(mode, distance, size, bin);
      requests_sent++;
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      logic signed [DIST_W-1:0]  distance;
      logic        [SIZE_W-1:0]  size;
      logic        [INDEX_W-1:0] bin;
      int                        pick;
      distance = $urandom();
      size     = SIZE_W'($urandom());
      bin      = INDEX_W'($urandom_range(1023));
      if ($urandom_range(99) < 45) begin
         if ($urandom_range(7) != 0)
            bin = INDEX_W'($urandom_range(NUM_BINS_DEF - 1));
         else
            bin = INDEX_W'($urandom_range(NUM_BINS_DEF, 1023));
         send_request(MODE_READ, distance, size, bin);
      end else begin
         pick = $urandom_range(99);
         if (pick < 70)
            distance = int'($urandom_range(4300)) - 3150;
         else if (pick < 82)
            distance = ($urandom_range(1) ? -3000 : 1000) + int'($urandom_range(12)) - 6;
         pick = $urandom_range(99);
         if (pick < 80)
            size = SIZE_W'($urandom_range(500));
         else if (pick < 95)
            size = SIZE_W'($urandom_range(4500));
         send_request(MODE_ADD, distance, size, bin);
      end
   endtask

   // result side: random stall bursts, plus the long hold-off
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall)
         sb.check_result(rsp_read_bin, rsp_bin_count);
      if (rsp_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rsp_gap_pct != 0 && $urandom_range(99) < rsp_gap_pct) begin
         stall_left = $urandom_range(17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // hold results back long enough for the block to back up onto its input
   initial begin
      wait (requests_sent >= HOLD_START);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      int n;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: window edges, misses, partial cover, field extremes
      send_request(MODE_READ, 0, 0, 0);
      send_request(MODE_ADD, -3000, 0, 0);
      send_request(MODE_ADD, 999, 0, 0);
      send_request(MODE_ADD, 1000, 0, 0);
      send_request(MODE_ADD, -3001, 0, 0);
      send_request(MODE_ADD, -3003, 3, 0);
      send_request(MODE_ADD, -3003, 8, 0);
      send_request(MODE_ADD, 32'sh8000_0000, 24'hFF_FFFF, 0);
      send_request(MODE_ADD, 32'sh7FFF_FFFF, 24'hFF_FFFF, 10'h3FF);
      send_request(MODE_ADD, -3500, 24'hFF_FFFF, 0);
      send_request(MODE_ADD, 900, 500, 0);
      send_request(MODE_ADD, 0, 1000, 0);
      send_request(MODE_READ, 0, 0, 0);
      send_request(MODE_READ, 0, 0, 1);
      send_request(MODE_READ, 0, 0, 799);
      send_request(MODE_READ, 0, 0, 780);
      send_request(MODE_READ, 0, 0, 600);
      send_request(MODE_READ, 32'sh7FFF_FFFF, 24'hFF_FFFF, 800);
      send_request(MODE_READ, 0, 0, 1023);
      send_request(MODE_READ, 0, 0, 10'b10_1010_1010);
      send_request(MODE_READ, 0, 0, 10'b01_0101_0101);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n >= RANDOM_REQUESTS - QUIET_TAIL) begin
            send_gap_pct = 0;
            rsp_gap_pct <= 0;
         end else if (n % 150 == 0) begin
            case ($urandom_range(2))
               0: send_gap_pct = 0;
               1: send_gap_pct = 10;
               default: send_gap_pct = 35;
            endcase
            case ($urandom_range(2))
               0: rsp_gap_pct <= 0;
               1: rsp_gap_pct <= 8;
               default: rsp_gap_pct <= 30;
            endcase
         end
         send_random_request();
      end
      req_valid <= 1'b0;

      while (sb.read_bins.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* files.f */
+incdir+rtl
rtl/tpch_pkg.sv
rtl/tpch_ram.sv
rtl/tpch_sub.sv
rtl/tss_proximity_coverage_histogram.sv
test/tb_tss_proximity_coverage_histogram.sv
